FILE: design/lsh_pkg.sv
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared types, constants and helpers of the LSH-256 hash engine.
// ----------------------------------------------------------------------------
package lsh_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int STEP_COUNT  = 26;
    localparam int MAX_OUT     = 32;

    localparam logic [1:0] OP_RESTART  = 2'd0;
    localparam logic [1:0] OP_ABSORB   = 2'd1;
    localparam logic [1:0] OP_FINALIZE = 2'd2;
    localparam logic [1:0] OP_NOP      = 2'd3;

    localparam logic CFG_HASH_BYTES = 1'b0;
    localparam logic CFG_DROP_BITS  = 1'b1;

    localparam logic [31:0] SC_FIRST [8] = '{
        32'h917caf90, 32'h6c1b10a2, 32'h6f352943, 32'hcf778243,
        32'h2ceb7472, 32'h29e96ff2, 32'h8a9ba428, 32'h2eeb2642
    };
    localparam logic [2:0] TAU_IDX [8] = '{3'd3, 3'd2, 3'd0, 3'd1, 3'd7, 3'd4, 3'd5, 3'd6};
    localparam logic [3:0] SIGMA_IDX [16] = '{
        4'd6, 4'd4, 4'd5, 4'd7, 4'd12, 4'd15, 4'd14, 4'd13,
        4'd2, 4'd0, 4'd1, 4'd3, 4'd8, 4'd11, 4'd10, 4'd9
    };

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LOAD = 8'b0000_0010,
        S_EXP  = 8'b0000_0100,
        S_ADD  = 8'b0000_1000,
        S_MIX  = 8'b0001_0000,
        S_PERM = 8'b0010_0000,
        S_XORH = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } state_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
        logic [63:0] d;
        d = {x, x} << r;
        return d[63:32];
    endfunction

    function automatic logic [31:0] gamma_rot(input logic [31:0] x, input logic [2:0] i);
        logic [31:0] y;
        unique case (i)
            3'd0, 3'd7: y = x;
            3'd1, 3'd6: y = {x[23:0], x[31:24]};
            3'd2, 3'd5: y = {x[15:0], x[31:16]};
            default:    y = {x[7:0], x[31:8]};
        endcase
        return y;
    endfunction

    function automatic logic [5:0] eff_bytes(input logic [5:0] hb);
        logic [5:0] n;
        priority if (hb == 6'd0)
            n = 6'd1;
        else if (hb > 6'(MAX_OUT))
            n = 6'(MAX_OUT);
        else
            n = hb;
        return n;
    endfunction

endpackage

FILE: design/lsh_ram.sv
// ----------------------------------------------------------------------------
// lsh_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/lsh256_hash_engine.sv
// ----------------------------------------------------------------------------
// lsh256_hash_engine
// Byte-stream LSH-256 hash with a word-pair mix unit under a step sequencer.
// ----------------------------------------------------------------------------
// Each input beat is an operation: restart (load IV), absorb one byte,
// finalize and emit the digest, or no-op. An absorb that does not fill the
// 128-byte buffer only writes its byte there. A restart, a buffer-filling
// absorb and a finalize keep s_axis_tready low while the sequencer runs. For
// a block the buffer is read out of its RAM one byte a cycle, then 26 steps
// (expand, add, mix of the eight word pairs, permute) run through one shared
// mix unit that handles one word pair a cycle, plus a final message addition
// (expand, add). A restart skips the read-out and the message steps and runs
// 26 mix steps (mix of the eight word pairs, permute). After the block,
// finalize folds the halves, then emits hash_bytes digest beats (clamped to
// 1..32), one per cycle while m_axis_tready is high.
// ----------------------------------------------------------------------------
module lsh256_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // operation[1:0], data_byte[9:2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // hash_byte[7:0]
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data
);
    import lsh_pkg::*;

    state_t state_reg, state_next;
    logic [5:0]  hb_reg, hb_next;
    logic [2:0]  db_reg, db_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [6:0]  k_reg, k_next;
    logic        fin_reg, fin_next;
    logic        iv_reg, iv_next;
    logic        tail_reg, tail_next;
    logic [4:0]  j_reg, j_next;
    logic [2:0]  mi_reg, mi_next;
    logic [7:0]  ld_reg, ld_next;
    logic        rdv_reg, rdv_next;
    logic [6:0]  rdi_reg, rdi_next;
    logic [5:0]  ecnt_reg, ecnt_next;
    logic [5:0]  n_reg, n_next;
    logic [31:0] cv_reg [16];
    logic [31:0] cv_next [16];
    logic [31:0] sc_reg [8];
    logic [31:0] sc_next [8];
    logic [1023:0] msg_reg, msg_next;
    logic [255:0]  dig_reg, dig_next;
    logic        ov_reg, ov_next;
    logic [7:0]  od_reg, od_next;
    logic        ol_reg, ol_next;

    logic        ram_we;
    logic [6:0]  ram_waddr, ram_raddr;
    logic [7:0]  ram_wdata, ram_q;

    logic        acc;
    logic [1:0]  op;
    logic [7:0]  din;
    logic [7:0]  rd_byte;
    logic [31:0] mx_a, mx_b, mx_l, mx_r;
    logic        par;
    logic [31:0] half_dst [16];
    logic [31:0] half_oth [16];
    logic [31:0] half_new [16];
    logic [8:0]  out_bits;
    logic [7:0]  eb;
    logic [5:0]  eff;

    lsh_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign op  = s_axis_tdata[1:0];
    assign din = s_axis_tdata[9:2];
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;

    assign eff = eff_bytes(hb_reg);
    assign out_bits = {eff, 3'b000} - {6'd0, db_reg};

    assign rd_byte = (!fin_reg || (rdi_reg < k_reg)) ? ram_q :
                     ((rdi_reg == k_reg) ? 8'h80 : 8'h00);

    assign par = tail_reg ? 1'b0 : j_reg[0];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            half_dst[i] = par ? msg_reg[512 + 32*i +: 32] : msg_reg[32*i +: 32];
            half_oth[i] = par ? msg_reg[32*i +: 32] : msg_reg[512 + 32*i +: 32];
        end
        for (int h = 0; h < 2; h++)
        begin
            for (int i = 0; i < 8; i++)
            begin
                half_new[h*8 + i] = half_oth[h*8 + i] + half_dst[h*8 + int'(TAU_IDX[i])];
            end
        end
    end

    always_comb
    begin
        mx_a = j_reg[0] ? (rotl32(cv_reg[0] + cv_reg[8], 5'd5) ^ sc_reg[0])
                        : (rotl32(cv_reg[0] + cv_reg[8], 5'd29) ^ sc_reg[0]);
        mx_b = j_reg[0] ? rotl32(cv_reg[8] + mx_a, 5'd17) : rotl32(cv_reg[8] + mx_a, 5'd1);
        mx_l = mx_a + mx_b;
        mx_r = gamma_rot(mx_b, mi_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        hb_next = hb_reg;
        db_next = db_reg;
        cnt_next = cnt_reg;
        k_next = k_reg;
        fin_next = fin_reg;
        iv_next = iv_reg;
        tail_next = tail_reg;
        j_next = j_reg;
        mi_next = mi_reg;
        ld_next = ld_reg;
        rdv_next = 1'b0;
        rdi_next = rdi_reg;
        ecnt_next = ecnt_reg;
        n_next = n_reg;
        cv_next = cv_reg;
        sc_next = sc_reg;
        msg_next = msg_reg;
        dig_next = dig_reg;
        ov_next = ov_reg;
        od_next = od_reg;
        ol_next = ol_reg;
        ram_we = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = din;
        ram_raddr = ld_reg[6:0];
        eb = dig_reg[7:0];

        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HASH_BYTES: hb_next = cfg_data;
                default:        db_next = cfg_data[2:0];
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    priority case (op)
                        OP_RESTART:
                        begin
                            cnt_next = '0;
                            for (int i = 0; i < 16; i++)
                            begin
                                cv_next[i] = '0;
                            end
                            cv_next[0] = 32'(MAX_OUT);
                            cv_next[1] = {23'd0, out_bits};
                            sc_next = SC_FIRST;
                            iv_next = 1'b1;
                            tail_next = 1'b0;
                            fin_next = 1'b0;
                            j_next = '0;
                            mi_next = '0;
                            state_next = S_MIX;
                        end
                        OP_ABSORB:
                        begin
                            ram_we = 1'b1;
                            cnt_next = cnt_reg + 7'd1;
                            if (cnt_reg == 7'(BLOCK_BYTES - 1))
                            begin
                                fin_next = 1'b0;
                                ld_next = '0;
                                state_next = S_LOAD;
                            end
                        end
                        OP_FINALIZE:
                        begin
                            fin_next = 1'b1;
                            k_next = cnt_reg;
                            ld_next = '0;
                            state_next = S_LOAD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                if (!ld_reg[7])
                begin
                    rdv_next = 1'b1;
                    rdi_next = ld_reg[6:0];
                    ld_next = ld_reg + 8'd1;
                    if (fin_reg && (ld_reg[6:0] >= k_reg))
                    begin
                        ram_we = 1'b1;
                        ram_waddr = ld_reg[6:0];
                        ram_wdata = (ld_reg[6:0] == k_reg) ? 8'h80 : 8'h00;
                    end
                end
                if (rdv_reg)
                begin
                    msg_next = {rd_byte, msg_reg[1023:8]};
                    if (rdi_reg == 7'(BLOCK_BYTES - 1))
                    begin
                        sc_next = SC_FIRST;
                        iv_next = 1'b0;
                        tail_next = 1'b0;
                        j_next = '0;
                        state_next = S_EXP;
                    end
                end
            end
            S_EXP:
            begin
                if (tail_reg || (j_reg >= 5'd2))
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        if (par)
                            msg_next[512 + 32*i +: 32] = half_new[i];
                        else
                            msg_next[32*i +: 32] = half_new[i];
                    end
                end
                state_next = S_ADD;
            end
            S_ADD:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    cv_next[i] = cv_reg[i] ^ half_dst[i];
                end
                mi_next = '0;
                priority if (!tail_reg)
                    state_next = S_MIX;
                else if (fin_reg)
                    state_next = S_XORH;
                else
                    state_next = S_IDLE;
            end
            S_MIX:
            begin
                for (int i = 0; i < 7; i++)
                begin
                    cv_next[i] = cv_reg[i+1];
                    cv_next[i+8] = cv_reg[i+9];
                    sc_next[i] = sc_reg[i+1];
                end
                cv_next[7] = mx_l;
                cv_next[15] = mx_r;
                sc_next[7] = sc_reg[0];
                mi_next = mi_reg + 3'd1;
                if (mi_reg == 3'd7)
                begin
                    state_next = S_PERM;
                end
            end
            S_PERM:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    cv_next[i] = cv_reg[SIGMA_IDX[i]];
                end
                for (int i = 0; i < 8; i++)
                begin
                    sc_next[i] = sc_reg[i] + rotl32(sc_reg[i], 5'd8);
                end
                mi_next = '0;
                if (j_reg == 5'(STEP_COUNT - 1))
                begin
                    j_next = '0;
                    if (iv_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        tail_next = 1'b1;
                        state_next = S_EXP;
                    end
                end
                else
                begin
                    j_next = j_reg + 5'd1;
                    state_next = iv_reg ? S_MIX : S_EXP;
                end
            end
            S_XORH:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    cv_next[i] = cv_reg[i] ^ cv_reg[i+8];
                    dig_next[32*i +: 32] = cv_reg[i] ^ cv_reg[i+8];
                end
                n_next = eff;
                ecnt_next = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    if (ecnt_reg + 6'd1 == n_reg)
                    begin
                        eb = dig_reg[7:0] & (8'hff << db_reg);
                        state_next = S_IDLE;
                    end
                    ov_next = 1'b1;
                    od_next = eb;
                    ol_next = (ecnt_reg + 6'd1 == n_reg);
                    dig_next = {8'h00, dig_reg[255:8]};
                    ecnt_next = ecnt_reg + 6'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hb_reg <= 6'(MAX_OUT);
            db_reg <= '0;
            cnt_reg <= '0;
            fin_reg <= 1'b0;
            iv_reg <= 1'b0;
            tail_reg <= 1'b0;
            j_reg <= '0;
            mi_reg <= '0;
            ld_reg <= '0;
            rdv_reg <= 1'b0;
            ecnt_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hb_reg <= hb_next;
            db_reg <= db_next;
            cnt_reg <= cnt_next;
            fin_reg <= fin_next;
            iv_reg <= iv_next;
            tail_reg <= tail_next;
            j_reg <= j_next;
            mi_reg <= mi_next;
            ld_reg <= ld_next;
            rdv_reg <= rdv_next;
            ecnt_reg <= ecnt_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        rdi_reg <= rdi_next;
        n_reg <= n_next;
        cv_reg <= cv_next;
        sc_reg <= sc_next;
        msg_reg <= msg_next;
        dig_reg <= dig_next;
        od_reg <= od_next;
        ol_reg <= ol_next;
    end

endmodule

FILE: design/lsh_checker.sv
// ----------------------------------------------------------------------------
// lsh_checker
// Port-level checks of the LSH-256 hash engine, bound to the top level.
// ----------------------------------------------------------------------------
module lsh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);
    import lsh_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == OP_FINALIZE)
            |=> !s_axis_tready)
        else $error("finalize did not start the sequencer");

    a_rst_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == OP_RESTART)
            |=> !s_axis_tready)
        else $error("restart did not start the sequencer");

    a_out_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("digest beat appeared outside finalize");

endmodule

bind lsh256_hash_engine lsh_checker u_lsh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
